// ===== hdl/kdds_pkg.sv =====
// Shared constants, status codes and digit helpers of the keyed decimal digit scrambler.
`timescale 1ns / 1ps
`default_nettype none
package kdds_pkg;

	// Field widths of one transaction
	localparam int VALUE_W    = 30;
	localparam int STATUS_W   = 2;
	localparam int S_TDATA_W  = 64;   // value, key, zero fill
	localparam int M_TDATA_W  = 32;   // code, status

	// Decimal digits a 30-bit input can hold
	localparam int VAL_DIGITS = 10;

	// Binary rebuild of at most ten decimal digits
	localparam int BIN_W      = 34;

	// Default parameter values
	localparam int NUM_DIGITS_DEF = 9;
	localparam int MAX_ROUNDS_DEF = 64;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd2;

	// Reduce a running sum of at most 90 to one decimal digit
	function automatic logic [3:0] mod10(input logic [6:0] s);
		logic [17:0] p;
		logic [3:0]  q;
		logic [6:0]  r;
		p = {11'd0, s} * 18'd205;
		q = p[14:11];
		r = s - 7'({3'd0, q} * 7'd10);
		return r[3:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/keyed_decimal_digit_scramble.sv =====
// Top level of the keyed decimal digit scrambler: sequencer, digit store and shared digit MAC.
//
// One transaction carries a value and a key; the result is the value scrambled to the same
// number of decimal digits n, or a status that flags a zero value, a value wider than
// NUM_DIGITS digits or a spent round budget. Both inputs are first turned into decimal
// digits by a shift-add-3 converter, then the digit count is found. Each round runs one
// shared 4x4 digit multiplier with a mod-10 accumulator, one digit product per cycle, over
// the n(n+1)/2 products of the kept coefficients, then a step that closes the round; rounds
// repeat up to MAX_ROUNDS until the leading digit is nonzero. The result is then rebuilt in
// binary one digit per cycle and handed to the output register. The input side is ready
// only while the sequencer is idle; a finished result may wait in the output register while
// the next item is taken. A zero value skips the converter and the rounds.
`timescale 1ns / 1ps
`default_nettype none
module keyed_decimal_digit_scramble #(
	parameter int NUM_DIGITS = kdds_pkg::NUM_DIGITS_DEF,
	parameter int MAX_ROUNDS = kdds_pkg::MAX_ROUNDS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [kdds_pkg::S_TDATA_W-1:0] s_tdata,   // value[29:0], key[59:30], zeros
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [kdds_pkg::M_TDATA_W-1:0]      m_tdata    // code[29:0], status[31:30]
);
	import kdds_pkg::*;

	localparam int MAXD   = (NUM_DIGITS > VAL_DIGITS) ? NUM_DIGITS : VAL_DIGITS;
	localparam int BCD_W  = 4 * MAXD;
	localparam int CNT_W  = $clog2(MAXD + 1);
	localparam int IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int RND_W  = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
	localparam int CONV_W = $clog2(VALUE_W);

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CONV  = 3'd1;
	localparam logic [2:0] S_COUNT = 3'd2;
	localparam logic [2:0] S_MAC   = 3'd3;
	localparam logic [2:0] S_RND   = 3'd4;
	localparam logic [2:0] S_PACK  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]          state_q;
	logic [CONV_W-1:0]   conv_q;
	logic [VALUE_W-1:0]  vbin_q;
	logic [VALUE_W-1:0]  kbin_q;
	logic [BCD_W-1:0]    vbcd_q;
	logic [BCD_W-1:0]    kbcd_q;
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    i_q;
	logic [CNT_W-1:0]    j_q;
	logic [RND_W-1:0]    rnd_q;
	logic [3:0]          acc_q;
	logic [BIN_W-1:0]    bin_q;
	logic [STATUS_W-1:0] status_q;
	logic [3:0]          hd_q [NUM_DIGITS];
	logic [3:0]          kd_q [NUM_DIGITS];
	logic [3:0]          nd_q [NUM_DIGITS];
	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [BCD_W-1:0]    vbcd_adj;
	logic [BCD_W-1:0]    kbcd_adj;
	logic [CNT_W-1:0]    n_found;
	logic [CNT_W-1:0]    kidx;
	logic [6:0]          mac_sum;
	logic [3:0]          mac_dig;
	logic [CNT_W-1:0]    top_idx;
	logic [3:0]          lead_dig;
	logic                out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	// Add 3 to every digit of five or more before the next shift
	always_comb begin
		for (int d = 0; d < MAXD; d++) begin
			vbcd_adj[4*d +: 4] = (vbcd_q[4*d +: 4] > 4'd4) ?
				vbcd_q[4*d +: 4] + 4'd3 : vbcd_q[4*d +: 4];
			kbcd_adj[4*d +: 4] = (kbcd_q[4*d +: 4] > 4'd4) ?
				kbcd_q[4*d +: 4] + 4'd3 : kbcd_q[4*d +: 4];
		end
	end

	// Count the value's digits: one past the highest nonzero digit
	always_comb begin
		n_found = '0;
		for (int d = 0; d < VAL_DIGITS; d++) begin
			if (vbcd_q[4*d +: 4] != 4'd0) begin
				n_found = CNT_W'(d + 1);
			end
		end
	end

	// Shared digit multiply-accumulate, reduced mod 10 each step
	assign kidx    = i_q - j_q;
	assign mac_sum = ({3'd0, hd_q[j_q[IDX_W-1:0]]} * {3'd0, kd_q[kidx[IDX_W-1:0]]}) +
		{3'd0, acc_q};
	assign mac_dig = mod10(mac_sum);

	// Leading digit of the new round result
	assign top_idx  = n_q - CNT_W'(1);
	assign lead_dig = nd_q[top_idx[IDX_W-1:0]];

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			conv_q     <= '0;
			i_q        <= '0;
			j_q        <= '0;
			rnd_q      <= '0;
			status_q   <= ST_OK;
		end else begin
			// Raise the result valid on a finished item, drop it once taken
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (s_tdata[VALUE_W-1:0] == '0) begin
							status_q <= ST_ZERO;
							state_q  <= S_DONE;
						end else begin
							status_q <= ST_OK;
							conv_q   <= '0;
							state_q  <= S_CONV;
						end
					end
				end
				S_CONV: begin
					conv_q <= conv_q + CONV_W'(1);
					if (conv_q == CONV_W'(VALUE_W - 1)) begin
						state_q <= S_COUNT;
					end
				end
				S_COUNT: begin
					// A value longer than a round keeps can never reach n digits
					if (n_found > CNT_W'(NUM_DIGITS)) begin
						status_q <= ST_LIMIT;
						state_q  <= S_DONE;
					end else begin
						i_q     <= '0;
						j_q     <= '0;
						rnd_q   <= '0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					if (j_q == i_q) begin
						j_q <= '0;
						if (i_q == top_idx) begin
							state_q <= S_RND;
						end else begin
							i_q <= i_q + CNT_W'(1);
						end
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
				end
				S_RND: begin
					i_q <= '0;
					if (lead_dig != 4'd0) begin
						j_q     <= top_idx;
						state_q <= S_PACK;
					end else if (rnd_q == RND_W'(MAX_ROUNDS - 1)) begin
						status_q <= ST_LIMIT;
						state_q  <= S_DONE;
					end else begin
						rnd_q   <= rnd_q + RND_W'(1);
						state_q <= S_MAC;
					end
				end
				S_PACK: begin
					if (j_q == '0) begin
						state_q <= S_DONE;
					end else begin
						j_q <= j_q - CNT_W'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: converter, digit store, accumulator, binary rebuild, output
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				vbin_q <= s_tdata[VALUE_W-1:0];
				kbin_q <= s_tdata[2*VALUE_W-1:VALUE_W];
				vbcd_q <= '0;
				kbcd_q <= '0;
				bin_q  <= '0;
			end
			S_CONV: begin
				vbcd_q <= {vbcd_adj[BCD_W-2:0], vbin_q[VALUE_W-1]};
				kbcd_q <= {kbcd_adj[BCD_W-2:0], kbin_q[VALUE_W-1]};
				vbin_q <= {vbin_q[VALUE_W-2:0], 1'b0};
				kbin_q <= {kbin_q[VALUE_W-2:0], 1'b0};
			end
			S_COUNT: begin
				n_q   <= n_found;
				acc_q <= '0;
				for (int d = 0; d < NUM_DIGITS; d++) begin
					hd_q[d] <= vbcd_q[4*d +: 4];
					kd_q[d] <= kbcd_q[4*d +: 4];
				end
			end
			S_MAC: begin
				if (j_q == i_q) begin
					nd_q[i_q[IDX_W-1:0]] <= mac_dig;
					acc_q <= '0;
				end else begin
					acc_q <= mac_dig;
				end
			end
			S_RND: begin
				// Keep the low n digits of the round result
				for (int d = 0; d < NUM_DIGITS; d++) begin
					hd_q[d] <= (CNT_W'(d) < n_q) ? nd_q[d] : 4'd0;
				end
			end
			S_PACK: begin
				bin_q <= (bin_q << 3) + (bin_q << 1) + BIN_W'(hd_q[j_q[IDX_W-1:0]]);
			end
			S_DONE: begin
				if (out_free) begin
					m_tdata_q <= {status_q,
						(status_q == ST_OK) ? bin_q[VALUE_W-1:0] : {VALUE_W{1'b0}}};
				end
			end
			default: begin
				acc_q <= '0;
			end
		endcase
	end

	// Checks on the sequencer and the result
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31:30] == ST_OK || m_tdata[31:30] == ST_ZERO ||
			m_tdata[31:30] == ST_LIMIT))
		else $error("result carries an unknown status");

	a_flag_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[31:30] != ST_OK) |-> (m_tdata[29:0] == '0))
		else $error("flagged result has a nonzero code");

	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[31:30] == ST_OK) |-> (m_tdata[29:0] != '0))
		else $error("good result lost its leading digit");

	a_mac_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC) |-> (j_q <= i_q && i_q < n_q && n_q != '0))
		else $error("digit product indexes out of range");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC || state_q == S_RND) |=> !(s_tready && $past(state_q) == S_MAC &&
			state_q == S_IDLE))
		else $error("sequencer left a round without closing it");

endmodule
`default_nettype wire

// ===== tb/tb_keyed_decimal_digit_scramble.sv =====
// Self-checking testbench of the keyed decimal digit scrambler with its own digit-product predictor.
`timescale 1ns / 1ps
module tb_keyed_decimal_digit_scramble;
	import kdds_pkg::*;

	localparam int NDIG = NUM_DIGITS_DEF;
	localparam int ROUND_CAP = MAX_ROUNDS_DEF;
	localparam int RANDOM_ITEMS = 1600;
	// Longest item: every round spent on nine digits, plus conversion and rebuild
	localparam int DRAIN_CYCLES = 4000;
	localparam longint TIMEOUT_NS = 250_000_000;
	localparam int unsigned FIELD_MAX = 32'h3FFF_FFFF;

	typedef struct packed {
		logic [VALUE_W-1:0] key;
		logic [VALUE_W-1:0] value;
	} scramble_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  code;
	} scramble_res_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // value[29:0], key[59:30], zeros
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // code[29:0], status[31:30]

	scramble_req_t stim_items[$];
	scramble_res_t expected_codes[$];
	scramble_req_t cur_req;
	int            total_items = 1;
	int            sent_cnt = 0;
	int            recv_cnt = 0;
	int            fail_cnt = 0;
	int            ok_cnt = 0;
	int            zero_cnt = 0;
	int            limit_cnt = 0;

	keyed_decimal_digit_scramble #(
		.NUM_DIGITS(NDIG),
		.MAX_ROUNDS(ROUND_CAP)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Carry-free product of the low digits of a and b, each coefficient mod 10
	function automatic longint unsigned digit_convolve(input longint unsigned a,
			input longint unsigned b);
		int unsigned     da[NDIG];
		int unsigned     db[NDIG];
		int unsigned     coef;
		longint unsigned acc;
		longint unsigned place;
		acc = 0;
		place = 1;
		for (int i = 0; i < NDIG; i++) begin
			da[i] = 32'(a % 10);
			a = a / 10;
			db[i] = 32'(b % 10);
			b = b / 10;
		end
		for (int i = 0; i < NDIG; i++) begin
			coef = 0;
			for (int j = 0; j <= i; j++)
				coef += da[j] * db[i-j];
			acc += place * 64'(coef % 10);
			place *= 10;
		end
		return acc;
	endfunction

	// Repeat rounds until the result keeps the digit count of the value
	function automatic scramble_res_t scramble_digits(input scramble_req_t req);
		scramble_res_t   res;
		longint unsigned span;
		longint unsigned floor_v;
		longint unsigned h;
		res.code = '0;
		res.status = ST_LIMIT;
		if (req.value == 0) begin
			res.status = ST_ZERO;
			return res;
		end
		span = 1;
		while (req.value >= span)
			span *= 10;
		floor_v = span / 10;
		h = req.value;
		for (int r = 0; r < ROUND_CAP; r++) begin
			h = digit_convolve(h, req.key) % span;
			if (h >= floor_v) begin
				res.code = h[VALUE_W-1:0];
				res.status = ST_OK;
				return res;
			end
		end
		return res;
	endfunction

	// Idle share in percent: sender 16/85/0, receiver 85/16/0 over the three thirds
	function automatic int idle_share(input int done, input bit receiver);
		int third;
		third = done * 3 / total_items;
		case (third)
			0:       return receiver ? 85 : 16;
			1:       return receiver ? 16 : 85;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned ten_pow(input int e);
		int unsigned p;
		p = 1;
		repeat (e) p *= 10;
		return p;
	endfunction

	task automatic add_item(input int unsigned value, input int unsigned key);
		scramble_req_t req;
		req.value = value[VALUE_W-1:0];
		req.key = key[VALUE_W-1:0];
		stim_items.push_back(req);
	endtask

	// Present queued transactions; record the expected result on each accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_codes.push_back(scramble_digits(cur_req));
				sent_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (stim_items.size() != 0 &&
						$urandom_range(99) >= idle_share(sent_cnt, 1'b0)) begin
					cur_req = stim_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {4'd0, cur_req.key, cur_req.value};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Compare each result transaction with the oldest expectation; stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				recv_cnt++;
				if (expected_codes.size() == 0) begin
					$error("unexpected result: code %0d status %0d",
						m_tdata[VALUE_W-1:0], m_tdata[M_TDATA_W-1 -: STATUS_W]);
					fail_cnt++;
				end else begin
					scramble_res_t want;
					want = expected_codes.pop_front();
					if (m_tdata[VALUE_W-1:0] !== want.code) begin
						$error("code: expected %0d, got %0d", want.code, m_tdata[VALUE_W-1:0]);
						fail_cnt++;
					end
					if (m_tdata[M_TDATA_W-1 -: STATUS_W] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status,
							m_tdata[M_TDATA_W-1 -: STATUS_W]);
						fail_cnt++;
					end
					case (want.status)
						ST_OK:   ok_cnt++;
						ST_ZERO: zero_cnt++;
						default: limit_cnt++;
					endcase
				end
			end
			m_tready <= ($urandom_range(99) >= idle_share(recv_cnt, 1'b1));
		end
	end

	// Build stimulus, release reset, drain and report
	initial begin
		int unsigned sel;
		int unsigned n;
		int unsigned v;
		int unsigned k;

		// Zero value, with and without a key
		add_item(0, 0);
		add_item(0, 987654321);
		// Zero key, and a key whose low nine digits are all zero: round limit
		add_item(123456789, 0);
		add_item(55, 1000000000);
		// Single-digit value whose product is always zero: round limit
		add_item(5, 2);
		// Smallest and largest values, with the identity key and with other keys
		add_item(1, 1);
		add_item(9, 9);
		add_item(10, 1);
		add_item(100000000, 3);
		add_item(999999999, 1);
		add_item(999999999, 999999999);
		// Values wider than nine digits never reach their digit count
		add_item(1000000000, 1);
		add_item(FIELD_MAX, 123456789);
		// Key digits above position eight are dropped
		add_item(123456789, FIELD_MAX);
		add_item(123456789, 1000000007);
		// Key with a zero low digit shifts the value up
		add_item(12, 10);
		add_item(4321, 1010);
		// Full fields, and the top bit alone, on both sides
		add_item(FIELD_MAX, FIELD_MAX);
		add_item(536870912, 536870912);
		for (int d = 1; d <= NDIG; d++)
			add_item(ten_pow(d) - 1, $urandom_range(999999999, 1));

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			sel = $urandom_range(99);
			if (sel < 3)
				v = 0;
			else if (sel < 6)
				v = $urandom_range(FIELD_MAX, 1000000000);
			else begin
				n = $urandom_range(NDIG, 1);
				v = $urandom_range(ten_pow(n) - 1, ten_pow(n - 1));
			end
			sel = $urandom_range(99);
			if (sel < 2)
				k = 0;
			else if (sel < 7)
				k = $urandom_range(FIELD_MAX, 1000000000);
			else if (sel < 17)
				k = $urandom_range(99, 1);
			else
				k = $urandom_range(999999999, 1);
			add_item(v, k);
		end
		total_items = stim_items.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_cnt < total_items || expected_codes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Scrambled %0d transactions: %0d kept their digit count, %0d zero values,",
			recv_cnt, ok_cnt, zero_cnt);
		$display("%0d round limits; stalls swept through three idle mixes; %0d check failures",
			limit_cnt, fail_cnt);
		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Hang guard
	initial begin
		#(TIMEOUT_NS);
		$display("TB_ERROR");
		$finish;
	end

endmodule
